/* rtl/tccs_pkg.sv */
`default_nettype none

package tccs_pkg;

  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;

  localparam logic [7:0] NEWLINE_CODE   = 8'd10;
  localparam logic [7:0] SPACE_CODE     = 8'h20;
  localparam logic [7:0] COLOUR_BLACK   = 8'h00;
  localparam logic [7:0] COLOUR_L_GRAY  = 8'h07;

  localparam logic [15:0] RESET_CELL = {COLOUR_L_GRAY, SPACE_CODE};
  localparam logic [15:0] BLANK_CELL = {COLOUR_BLACK, SPACE_CODE};

  localparam logic [7:0] TEXT_COLOUR_RST = COLOUR_L_GRAY;

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_READ  = 1'b1;

  typedef enum logic [4:0] {
    ST_CLEAR  = 5'b00001,
    ST_IDLE   = 5'b00010,
    ST_READ   = 5'b00100,
    ST_SCROLL = 5'b01000,
    ST_FILL   = 5'b10000
  } tccs_state_t;

endpackage

`default_nettype wire

/* rtl/text_console_cursor_scroll_top.sv */
`default_nettype none

// channel  | dir | tdata (low bit up)                          | tuser
// ---------+-----+---------------------------------------------+---------
// in_      | in  | char_code[7:0], cell_index[18:8], pad 23:19 | kind
// out_     | out | cell_word[15:0], cursor_row[20:16],         | scrolled
//          |     | cursor_col[27:21], pad 31:28                |
// cfg_     | in  | cfg_wr_data = text_colour                   | -
//
// without a scroll, a character or newline result is registered the next cycle
// a read request goes through the registered read port of the cell memory, then ST_READ
// a scroll follows the accepting cycle: one cell moved per cycle
//   through the single read and write port, then the bottom row filled with blanks
// after reset a clearing pass fills every cell of the memory, in_tready stays low
// in_tready is low while a request is in work or a result is held and not being taken

module text_console_cursor_scroll_top
  import tccs_pkg::*;
#(
  parameter int COLUMNS = COLUMNS_DEF,
  parameter int ROWS    = ROWS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // char_code[7:0], cell_index[18:8]
  input  wire logic        in_tuser,   // kind
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // cell_word[15:0], cursor_row[20:16], cursor_col[27:21]
  output logic             out_tuser,  // scrolled
  input  wire logic        cfg_wr_en,
  input  wire logic [7:0]  cfg_wr_data
);

  localparam int CELL_COUNT = COLUMNS * ROWS;
  localparam int AW = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
  localparam int CW = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1;

  localparam logic [AW-1:0] LAST_CELL = AW'(CELL_COUNT - 1);
  localparam logic [AW-1:0] FILL_BASE = AW'(CELL_COUNT - COLUMNS);
  localparam logic [AW-1:0] ROW_STEP  = AW'(COLUMNS);
  localparam logic [CW-1:0] COL_LAST  = CW'(COLUMNS - 1);
  localparam logic [RW-1:0] ROW_LAST  = RW'(ROWS - 1);

  // cell memory
  logic [15:0]   mem [CELL_COUNT];
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [15:0]   mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  logic [15:0]   mem_rdata_r;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) mem_rdata_r <= mem[mem_raddr];
  end

  tccs_state_t   state_r, state_nxt;
  logic [AW-1:0] addr_r, addr_nxt;
  logic [AW-1:0] dst_r, dst_nxt;
  logic          pend_r, pend_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic [CW-1:0] col_r, col_nxt;
  logic [7:0]    colour_r;
  logic          rd_ok_r, rd_ok_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [15:0]   out_word_r, out_word_nxt;
  logic          out_scr_r, out_scr_nxt;

  logic          in_acc;
  logic [7:0]    in_char;
  logic [31:0]   idx_ext;
  logic [AW-1:0] cur_pos;
  logic          wrap;
  logic [31:0]   row_ext;
  logic [31:0]   col_ext;

  assign in_tready = (state_r == ST_IDLE) && (!out_valid_r || out_tready);
  assign in_acc    = in_tvalid && in_tready;
  assign in_char   = in_tdata[7:0];
  assign idx_ext   = {21'd0, in_tdata[18:8]};
  assign cur_pos   = AW'(row_r * COLUMNS) + AW'(col_r);
  assign wrap      = (in_char == NEWLINE_CODE) || (col_r == COL_LAST);

  always_comb begin
    state_nxt     = state_r;
    addr_nxt      = addr_r;
    dst_nxt       = dst_r;
    pend_nxt      = pend_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    rd_ok_nxt     = rd_ok_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_word_nxt  = out_word_r;
    out_scr_nxt   = out_scr_r;
    mem_we        = 1'b0;
    mem_waddr     = addr_r;
    mem_wdata     = RESET_CELL;
    mem_re        = 1'b0;
    mem_raddr     = addr_r;

    unique case (state_r)
      ST_CLEAR: begin
        mem_we = 1'b1;
        if (addr_r == LAST_CELL) begin
          addr_nxt  = '0;
          state_nxt = ST_IDLE;
        end else begin
          addr_nxt = addr_r + 1'b1;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          if (in_tuser == KIND_READ) begin
            mem_re    = 1'b1;
            mem_raddr = idx_ext[AW-1:0];
            rd_ok_nxt = idx_ext < 32'(CELL_COUNT);
            state_nxt = ST_READ;
          end else begin
            if (in_char != NEWLINE_CODE) begin
              mem_we    = 1'b1;
              mem_waddr = cur_pos;
              mem_wdata = {colour_r, in_char};
            end
            if (wrap) begin
              col_nxt = '0;
              if (row_r == ROW_LAST) begin
                addr_nxt  = ROW_STEP;
                pend_nxt  = 1'b0;
                state_nxt = ST_SCROLL;
              end else begin
                row_nxt       = row_r + 1'b1;
                out_valid_nxt = 1'b1;
                out_word_nxt  = '0;
                out_scr_nxt   = 1'b0;
              end
            end else begin
              col_nxt       = col_r + 1'b1;
              out_valid_nxt = 1'b1;
              out_word_nxt  = '0;
              out_scr_nxt   = 1'b0;
            end
          end
        end
      end
      ST_READ: begin
        out_valid_nxt = 1'b1;
        out_word_nxt  = rd_ok_r ? mem_rdata_r : 16'd0;
        out_scr_nxt   = 1'b0;
        state_nxt     = ST_IDLE;
      end
      ST_SCROLL: begin
        // read one row down, write the previous read one row up
        mem_re    = 1'b1;
        mem_raddr = addr_r;
        if (pend_r) begin
          mem_we    = 1'b1;
          mem_waddr = dst_r;
          mem_wdata = mem_rdata_r;
        end
        pend_nxt = 1'b1;
        dst_nxt  = addr_r - ROW_STEP;
        if (addr_r == LAST_CELL) begin
          addr_nxt  = FILL_BASE;
          state_nxt = ST_FILL;
        end else begin
          addr_nxt = addr_r + 1'b1;
        end
      end
      ST_FILL: begin
        mem_we = 1'b1;
        if (pend_r) begin
          // last moved cell goes out first
          mem_waddr = dst_r;
          mem_wdata = mem_rdata_r;
          pend_nxt  = 1'b0;
        end else begin
          mem_waddr = addr_r;
          mem_wdata = BLANK_CELL;
          if (addr_r == LAST_CELL) begin
            addr_nxt      = '0;
            out_valid_nxt = 1'b1;
            out_word_nxt  = '0;
            out_scr_nxt   = 1'b1;
            state_nxt     = ST_IDLE;
          end else begin
            addr_nxt = addr_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
        addr_nxt  = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      addr_r      <= '0;
      pend_r      <= 1'b0;
      row_r       <= '0;
      col_r       <= '0;
      colour_r    <= TEXT_COLOUR_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      addr_r      <= addr_nxt;
      pend_r      <= pend_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) colour_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    dst_r      <= dst_nxt;
    rd_ok_r    <= rd_ok_nxt;
    out_word_r <= out_word_nxt;
    out_scr_r  <= out_scr_nxt;
  end

  // cursor only moves on an accepted request, so it is stable while a result is held
  assign row_ext    = 32'(row_r);
  assign col_ext    = 32'(col_r);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, col_ext[6:0], row_ext[4:0], out_word_r};
  assign out_tuser  = out_scr_r;

  a_no_result_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_CLEAR |-> !out_valid_r)
    else $error("result valid during clearing pass");

  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    (row_r <= ROW_LAST) && (col_r <= COL_LAST))
    else $error("cursor out of range");

  a_scroll_cursor: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCROLL || state_r == ST_FILL) |-> (row_r == ROW_LAST && col_r == '0))
    else $error("cursor not on last row during scroll");

  a_scroll_src: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SCROLL |-> addr_r >= ROW_STEP)
    else $error("scroll source above second row");

  a_scrolled_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_scr_r) |-> (row_r == ROW_LAST && col_r == '0 && out_word_r == 16'd0))
    else $error("scrolled result with wrong cursor or data");

endmodule

`default_nettype wire
